// File: sv/ohbl_pkg.sv
// shared types and constants of the obstacle height lookup
package ohbl_pkg;

  localparam int DataW = 32;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_HEIGHT    = 3'd0,
    REG_X_START        = 3'd1,
    REG_X_RAMP_END     = 3'd2,
    REG_X_PLATEAU_END  = 3'd3,
    REG_X_END          = 3'd4,
    REG_OBSTACLE_LEVEL = 3'd5,
    REG_HALF_WIDTH     = 3'd6,
    REG_EDGE_RAMP      = 3'd7
  } reg_e;

  // which grid cell along one axis: entry ramp, plateau or exit ramp
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_FLAT = 2'd1,
    SEG_FALL = 2'd2
  } seg_e;

  typedef struct packed {
    logic signed [31:0] base_height;
    logic signed [31:0] x_start;
    logic signed [31:0] x_ramp_end;
    logic signed [31:0] x_plateau_end;
    logic signed [31:0] x_end;
    logic signed [31:0] obstacle_level;
    logic [30:0]        half_width;
    logic [30:0]        edge_ramp;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    seg_e        seg_x;
    seg_e        seg_y;
    logic [31:0] num_x;
    logic [31:0] den_x;
    logic [31:0] num_y;
    logic [31:0] den_y;
  } item_t;

endpackage

// File: sv/obstacle_height_bilinear_lookup.sv
// top level of the obstacle height lookup: configuration registers, front end, queue, back end
//
// Query points enter on a queue-style port: a transaction is taken at a rising edge with
// push high and full low. Results leave the same way: while empty is low the oldest height
// is on height_o, and it is taken at a rising edge with pop high and empty low.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i, one per cycle; the user
// must write them only while no transaction is in flight, which the block does not enforce.
// Throughput is one point per cycle while pop keeps up with results. A point passes from the
// queue through the two pipelined fraction dividers, one quotient bit per stage, then a weight
// multiply, a level multiply and the saturating output register before it shows on height_o.
// When pop stays low the back end pipeline freezes behind its full output register; the
// front end keeps taking points until the QUEUE_DEPTH-entry queue fills and full rises.
// Reset empties the queue and pipeline and loads the default obstacle geometry:
// ramps of one metre, half width three metres, edge ramp one metre, level and base zero.
module obstacle_height_bilinear_lookup import ohbl_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   height_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [DataW-1:0]     cfg_wdata_i
);

  localparam int One = 1 << FRAC_BITS;

  cfg_t  cfg_q;
  item_t front_item;
  item_t q_item;
  logic  q_wr;
  logic  q_rd;
  logic  q_full;
  logic  q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_height    <= '0;
      cfg_q.x_start        <= '0;
      cfg_q.x_ramp_end     <= 32'(One);
      cfg_q.x_plateau_end  <= 32'(2 * One);
      cfg_q.x_end          <= 32'(3 * One);
      cfg_q.obstacle_level <= '0;
      cfg_q.half_width     <= 31'(3 * One);
      cfg_q.edge_ramp      <= 31'(One);
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_BASE_HEIGHT:    cfg_q.base_height    <= cfg_wdata_i;
        REG_X_START:        cfg_q.x_start        <= cfg_wdata_i;
        REG_X_RAMP_END:     cfg_q.x_ramp_end     <= cfg_wdata_i;
        REG_X_PLATEAU_END:  cfg_q.x_plateau_end  <= cfg_wdata_i;
        REG_X_END:          cfg_q.x_end          <= cfg_wdata_i;
        REG_OBSTACLE_LEVEL: cfg_q.obstacle_level <= cfg_wdata_i;
        REG_HALF_WIDTH:     cfg_q.half_width     <= cfg_wdata_i[30:0];
        REG_EDGE_RAMP:      cfg_q.edge_ramp      <= cfg_wdata_i[30:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  ohbl_front u_front (
    .push_i   (push),
    .q_full_i (q_full),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .cfg_i    (cfg_q),
    .q_wr_o   (q_wr),
    .item_o   (front_item)
  );

  ohbl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .item_i  (front_item),
    .rd_i    (q_rd),
    .item_o  (q_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ohbl_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .item_i           (q_item),
    .q_rd_o           (q_rd),
    .base_height_i    (cfg_q.base_height),
    .obstacle_level_i (cfg_q.obstacle_level),
    .pop_i            (pop),
    .empty_o          (empty),
    .height_o         (height_o)
  );

  assign full = q_full;

  a_rd_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_empty)
    else $error("queue read while empty");

  a_stall_holds_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |-> !q_rd)
    else $error("back end advanced while result stalled");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !q_empty)
    else $error("accepted transaction missing from queue");

endmodule

// File: sv/ohbl_front.sv
// front end: classifies a query point into grid cells and fraction operands
module ohbl_front import ohbl_pkg::*; (
  input  logic               push_i,
  input  logic               q_full_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  cfg_t               cfg_i,
  output logic               q_wr_o,
  output item_t              item_o
);

  logic signed [33:0] bx [4];
  logic signed [33:0] by [4];
  logic signed [33:0] dx [4];
  logic signed [33:0] dy [4];
  logic signed [33:0] wx [3];
  logic signed [33:0] wy [3];
  logic [2:0]         cx;
  logic [2:0]         cy;
  logic               in_x;
  logic               in_y;

  always_comb begin
    bx[0] = 34'(cfg_i.x_start);
    bx[1] = 34'(cfg_i.x_ramp_end);
    bx[2] = 34'(cfg_i.x_plateau_end);
    bx[3] = 34'(cfg_i.x_end);
    by[3] = $signed({3'b000, cfg_i.half_width});
    by[0] = -by[3];
    by[1] = by[0] + $signed({3'b000, cfg_i.edge_ramp});
    by[2] = by[3] - $signed({3'b000, cfg_i.edge_ramp});
    for (int i = 0; i < 4; i++) begin
      dx[i] = 34'(pos_x_i) - bx[i];
      dy[i] = 34'(pos_y_i) - by[i];
    end
    for (int i = 0; i < 3; i++) begin
      wx[i] = bx[i+1] - bx[i];
      wy[i] = by[i+1] - by[i];
      cx[i] = !dx[i][33] && dx[i+1][33];
      cy[i] = !dy[i][33] && dy[i+1][33];
    end
    in_x = !dx[0][33] && (dx[0] != '0) && dx[3][33];
    in_y = !dy[0][33] && (dy[0] != '0) && dy[3][33];
  end

  always_comb begin
    item_o = '0;
    item_o.ok = in_x && in_y && (|cx) && (|cy);
    if (cx[0]) begin
      item_o.seg_x = SEG_RISE;
      item_o.num_x = dx[0][31:0];
      item_o.den_x = wx[0][31:0];
    end else if (cx[1]) begin
      item_o.seg_x = SEG_FLAT;
      item_o.num_x = dx[1][31:0];
      item_o.den_x = wx[1][31:0];
    end else begin
      item_o.seg_x = SEG_FALL;
      item_o.num_x = dx[2][31:0];
      item_o.den_x = wx[2][31:0];
    end
    if (cy[0]) begin
      item_o.seg_y = SEG_RISE;
      item_o.num_y = dy[0][31:0];
      item_o.den_y = wy[0][31:0];
    end else if (cy[1]) begin
      item_o.seg_y = SEG_FLAT;
      item_o.num_y = dy[1][31:0];
      item_o.den_y = wy[1][31:0];
    end else begin
      item_o.seg_y = SEG_FALL;
      item_o.num_y = dy[2][31:0];
      item_o.den_y = wy[2][31:0];
    end
  end

  assign q_wr_o = push_i && !q_full_i;

endmodule

// File: sv/ohbl_queue.sv
// small transaction queue between front end and back end
module ohbl_queue import ohbl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t item_i,
  input  logic  rd_i,
  output item_t item_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_i, rd_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

// File: sv/ohbl_div.sv
// pipelined restoring divider, one quotient bit per stage, for fractions below one
module ohbl_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [31:0]          num_i,
  input  logic [31:0]          den_i,
  output logic [FRAC_BITS-1:0] quot_o
);

  logic [31:0]          rem_q  [FRAC_BITS-1];
  logic [31:0]          den_q  [FRAC_BITS-1];
  logic [FRAC_BITS-1:0] quot_q [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic [31:0]          rem_in;
    logic [31:0]          den_in;
    logic [FRAC_BITS-1:0] quot_in;
    logic [33:0]          diff;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    assign diff = {1'b0, rem_in, 1'b0} - {2'b00, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[k] <= {quot_in[FRAC_BITS-2:0], !diff[33]};
      end
    end

    if (k < FRAC_BITS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[k] <= den_in;
          rem_q[k] <= diff[33] ? {rem_in[30:0], 1'b0} : diff[31:0];
        end
      end
    end
  end

  assign quot_o = quot_q[FRAC_BITS-1];

endmodule

// File: sv/ohbl_back.sv
// back end: fraction division, bilinear weight, scaling, saturation and result register
module ohbl_back import ohbl_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  item_t              item_i,
  output logic               q_rd_o,
  input  logic signed [31:0] base_height_i,
  input  logic signed [31:0] obstacle_level_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic signed [31:0] height_o
);

  localparam int WW = FRAC_BITS + 1;
  localparam int SW = 2 * FRAC_BITS + 2;
  localparam int PW = FRAC_BITS + 34;
  localparam logic [WW-1:0] One = WW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] HalfS = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW:0] HalfP = (PW+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [35:0] SatMax = 36'sd2147483647;
  localparam logic signed [35:0] SatMin = -36'sd2147483648;

  logic                 en;
  logic [FRAC_BITS-1:0] tx, ty;
  logic                 vld_q [FRAC_BITS];
  logic                 ok_q  [FRAC_BITS];
  seg_e                 sx_q  [FRAC_BITS];
  seg_e                 sy_q  [FRAC_BITS];

  logic                 vm_q, okm_q;
  logic [SW-1:0]        s_q, s_d;
  logic [WW-1:0]        wxs, wys;

  logic                 vp_q, okp_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [SW-1:0]        w_sum;
  logic [WW-1:0]        w;

  logic signed [PW:0]   t;
  logic signed [PW:0]   d;
  logic signed [35:0]   h;
  logic signed [31:0]   height_d;
  logic                 out_valid_q;
  logic signed [31:0]   height_q;

  assign en     = !out_valid_q || pop_i;
  assign q_rd_o = en && !q_empty_i;

  ohbl_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (item_i.num_x),
    .den_i  (item_i.den_x),
    .quot_o (tx)
  );

  ohbl_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (item_i.num_y),
    .den_i  (item_i.den_y),
    .quot_o (ty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRAC_BITS; k++) begin
        vld_q[k] <= 1'b0;
      end
      vm_q        <= 1'b0;
      vp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= q_rd_o;
      for (int k = 1; k < FRAC_BITS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      vm_q        <= vld_q[FRAC_BITS-1];
      vp_q        <= vm_q;
      out_valid_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ok_q[0] <= item_i.ok;
      sx_q[0] <= item_i.seg_x;
      sy_q[0] <= item_i.seg_y;
      for (int k = 1; k < FRAC_BITS; k++) begin
        ok_q[k] <= ok_q[k-1];
        sx_q[k] <= sx_q[k-1];
        sy_q[k] <= sy_q[k-1];
      end
      okm_q  <= ok_q[FRAC_BITS-1];
      s_q    <= s_d;
      okp_q  <= okm_q;
      prod_q <= prod_d;
      if (vp_q) begin
        height_q <= height_d;
      end
    end
  end

  // weight of the obstacle nodes along each axis
  always_comb begin
    case (sx_q[FRAC_BITS-1])
      SEG_RISE: wxs = {1'b0, tx};
      SEG_FLAT: wxs = One;
      SEG_FALL: wxs = One - {1'b0, tx};
      default:  wxs = '0;
    endcase
    case (sy_q[FRAC_BITS-1])
      SEG_RISE: wys = {1'b0, ty};
      SEG_FLAT: wys = One;
      SEG_FALL: wys = One - {1'b0, ty};
      default:  wys = '0;
    endcase
    s_d = SW'(wxs) * SW'(wys);
  end

  always_comb begin
    w_sum  = s_q + HalfS;
    w      = WW'(w_sum >> FRAC_BITS);
    prod_d = PW'(obstacle_level_i) * PW'($signed({1'b0, w}));
  end

  always_comb begin
    t = (PW+1)'(prod_q) + HalfP;
    d = t >>> FRAC_BITS;
    if (okp_q) begin
      h = 36'(base_height_i) + 36'(d);
    end else begin
      h = 36'(base_height_i);
    end
    if (h > SatMax) begin
      height_d = 32'(SatMax);
    end else if (h < SatMin) begin
      height_d = 32'(SatMin);
    end else begin
      height_d = 32'(h);
    end
  end

  assign empty_o  = !out_valid_q;
  assign height_o = height_q;

endmodule
